// ===== hw/rtl/clnw_pkg.sv =====
`default_nettype none
package clnw_pkg;

  localparam logic [2:0] REQ_CMD    = 3'd0;
  localparam logic [2:0] REQ_DATA   = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_INIT   = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  localparam logic [14:0] HOLD_STROBE = 15'd1;
  localparam logic [14:0] HOLD_HI_GAP = 15'd200;
  localparam logic [14:0] HOLD_LO_GAP = 15'd2000;
  localparam logic [14:0] HOLD_POWER  = 15'd20000;
  localparam logic [14:0] HOLD_TAIL   = 15'd2000;

  localparam logic [2:0] INIT_LAST   = 3'd5;
  localparam logic [7:0] CURSOR_BASE = 8'h80;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [3:0] TAIL_NIBBLE = 4'h1;
  localparam logic [3:0] LEAD_NIBBLE = 4'h0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAD,
    ST_BYTE,
    ST_TAIL
  } state_t;

  typedef enum logic [1:0] {
    KIND_LEAD,
    KIND_BYTE,
    KIND_TAIL
  } kind_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    kind_t      kind;
    logic [1:0] phase;
    logic [2:0] idx;
    logic       last;
  } clnw_cmd_t;

  typedef struct packed {
    logic slot_free;
  } clnw_sts_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h33;
      3'd1: b = 8'h32;
      3'd2: b = 8'h28;
      3'd3: b = 8'h0C;
      3'd4: b = 8'h06;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  function automatic logic [6:0] row_offset(input logic [1:0] row);
    logic [6:0] o;
    unique case (row)
      2'd0: o = 7'h00;
      2'd1: o = 7'h40;
      2'd2: o = 7'h14;
      default: o = 7'h54;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/char_lcd_nibble_writer_top.sv =====
// The first pin-state item is registered from the lead or byte state entered when
// the request is taken, once the output slot is free. Throughput: one item per cycle
// while out_tready is high; the next request is taken the cycle after the last item
// is registered; init adds lead and tail items, clear a tail item, unknown types none.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_tvalid.
`default_nettype none
module char_lcd_nibble_writer_top
  import clnw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // byte_value[7:0], column[13:8], line[15:14]
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // enable[0], nibble[4:1], hold_us[19:5], zero[23:20]
  output logic             out_tuser,  // reg_select[0]
  output logic             out_tlast
);

  clnw_cmd_t   cmd;
  clnw_sts_t   sts;
  logic        enable;
  logic [3:0]  nibble;
  logic [14:0] hold_us;

  clnw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  clnw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_type   (in_tuser),
    .byte_value (in_tdata[7:0]),
    .column     (in_tdata[13:8]),
    .line       (in_tdata[15:14]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .reg_select (out_tuser),
    .enable     (enable),
    .nibble     (nibble),
    .hold_us    (hold_us),
    .last       (out_tlast)
  );

  assign out_tdata = {4'b0000, hold_us, nibble, enable};

endmodule
`default_nettype wire

// ===== hw/rtl/clnw_ctrl.sv =====
`default_nettype none
module clnw_ctrl
  import clnw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic [2:0] in_tuser,
  output logic           in_tready,
  input  clnw_sts_t      sts,
  output clnw_cmd_t      cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] type_r, type_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 2'd0;
      idx_r   <= 3'd0;
      type_r  <= REQ_CMD;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      type_r  <= type_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    type_nxt  = type_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.phase = phase_r;
    cmd.idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          type_nxt  = in_tuser;
          phase_nxt = 2'd0;
          idx_nxt   = 3'd0;
          if (in_tuser == REQ_INIT) begin
            state_nxt = ST_LEAD;
          end else if (in_tuser <= REQ_CLEAR) begin
            state_nxt = ST_BYTE;
          end
        end
      end
      ST_LEAD: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_LEAD;
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_BYTE;
          phase_nxt = phase_r + 2'd1;
          if (phase_r == 2'd3) begin
            if (type_r == REQ_INIT && idx_r != INIT_LAST) begin
              idx_nxt = idx_r + 3'd1;
            end else if (type_r == REQ_INIT || type_r == REQ_CLEAR) begin
              state_nxt = ST_TAIL;
            end else begin
              cmd.last  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_TAIL: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_TAIL;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/clnw_dp.sv =====
`default_nettype none
module clnw_dp
  import clnw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [2:0] req_type,
  input  wire logic [7:0] byte_value,
  input  wire logic [5:0] column,
  input  wire logic [1:0] line,
  input  clnw_cmd_t       cmd,
  output clnw_sts_t       sts,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic            reg_select,
  output logic            enable,
  output logic [3:0]      nibble,
  output logic [14:0]     hold_us,
  output logic            last
);

  logic [2:0]  type_r;
  logic [7:0]  bval_r;
  logic [5:0]  col_r;
  logic [1:0]  row_r;
  logic        valid_r, valid_nxt;
  logic        rs_r, en_r, last_r;
  logic [3:0]  nib_r;
  logic [14:0] hold_r;

  logic [6:0]  addr;
  logic [7:0]  cur_byte;
  logic        rs_nxt, en_nxt;
  logic [3:0]  nib_nxt;
  logic [14:0] hold_nxt;

  assign sts.slot_free = !valid_r || out_ready;

  assign addr = {1'b0, col_r} + row_offset(row_r);

  always_comb begin
    unique case (type_r)
      REQ_CMD, REQ_DATA: cur_byte = bval_r;
      REQ_CURSOR:        cur_byte = CURSOR_BASE | {1'b0, addr};
      REQ_INIT:          cur_byte = init_byte(cmd.idx);
      default:           cur_byte = CMD_CLEAR;
    endcase
  end

  always_comb begin
    rs_nxt   = 1'b0;
    en_nxt   = 1'b0;
    nib_nxt  = LEAD_NIBBLE;
    hold_nxt = HOLD_POWER;
    unique case (cmd.kind)
      KIND_BYTE: begin
        rs_nxt  = (type_r == REQ_DATA);
        en_nxt  = !cmd.phase[0];
        nib_nxt = cmd.phase[1] ? cur_byte[3:0] : cur_byte[7:4];
        unique case (cmd.phase)
          2'd1:    hold_nxt = HOLD_HI_GAP;
          2'd3:    hold_nxt = HOLD_LO_GAP;
          default: hold_nxt = HOLD_STROBE;
        endcase
      end
      KIND_TAIL: begin
        nib_nxt  = TAIL_NIBBLE;
        hold_nxt = HOLD_TAIL;
      end
      default: begin
        nib_nxt  = LEAD_NIBBLE;
        hold_nxt = HOLD_POWER;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= req_type;
      bval_r <= byte_value;
      col_r  <= column;
      row_r  <= line;
    end
    if (cmd.emit) begin
      rs_r   <= rs_nxt;
      en_r   <= en_nxt;
      nib_r  <= nib_nxt;
      hold_r <= hold_nxt;
      last_r <= cmd.last;
    end
  end

  assign out_valid  = valid_r;
  assign reg_select = rs_r;
  assign enable     = en_r;
  assign nibble     = nib_r;
  assign hold_us    = hold_r;
  assign last       = last_r;

endmodule
`default_nettype wire

// ===== hw/rtl/clnw_chk.sv =====
`default_nettype none
module clnw_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled item changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

  // strobe high always lasts 1 us
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[19:5] == 15'd1)
    else $error("strobe hold wrong");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[19:5] == 15'd200
      || out_tdata[19:5] == 15'd2000 || out_tdata[19:5] == 15'd20000)
    else $error("gap hold wrong");

  // a request always ends with the strobe low
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[0])
    else $error("last item with strobe high");

endmodule

bind char_lcd_nibble_writer_top clnw_chk u_clnw_chk (.*);
`default_nettype wire
